FILE: rtl/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and arithmetic helpers for the sensor
// compensation datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

    // configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CALIB  = 3'd0,
        REG_PRESS_LOW   = 3'd1,
        REG_PRESS_HIGH  = 3'd2,
        REG_MIXED_CALIB = 3'd3,
        REG_HUM_CALIB   = 3'd4
    } psc_reg_e;

    // register stages of each section
    localparam int FRONT_STAGES = 13;
    localparam int DIV_BITS     = 64;
    localparam int BACK_STAGES  = 6;
    localparam int LATENCY      = FRONT_STAGES + DIV_BITS + BACK_STAGES;

    // formula constants
    localparam logic [33:0] C_PRESS_TOFS  = 34'd128000;
    localparam logic [31:0] C_HUM_TOFS    = 32'd76800;
    localparam logic [31:0] C_HUM_ROUND   = 32'd16384;
    localparam logic [31:0] C_HUM_HB_OFS  = 32'd32768;
    localparam logic [31:0] C_HUM_HC_OFS  = 32'd2097152;
    localparam logic [31:0] C_HUM_HD_RND  = 32'd8192;
    localparam logic [31:0] C_HUM_MAX     = 32'd419430400;
    localparam logic [20:0] C_PRESS_FULL  = 21'd1048576;
    localparam logic [63:0] C_PRESS_BIAS  = 64'h0000_8000_0000_0000;
    localparam logic signed [16:0] C_PRESS_SCALE = 17'sd3125;
    localparam logic [31:0] C_TEMP_ROUND  = 32'd128;

    // request and result payloads
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } psc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } psc_out_t;

    // decoded calibration words
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
    } psc_calib_t;

    // one slot of the divider chain
    typedef struct packed {
        logic        vld;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
        logic        neg;
        logic        dz;
        logic [31:0] temp;
        logic [16:0] hum;
    } psc_div_t;

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    // low 64 bits of a times a signed 17-bit factor, two partial products
    function automatic logic [63:0] mul64x16(input logic [63:0] a,
                                             input logic signed [16:0] b);
        logic signed [49:0] lo;
        logic [31:0]        hi;
        lo = $signed({1'b0, a[31:0]}) * b;
        hi = a[63:32] * {{15{b[16]}}, b};
        return {{14{lo[49]}}, lo} + {hi, 32'b0};
    endfunction

endpackage

FILE: rtl/psc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_front
// Temperature and humidity formulas, and the pressure terms up to the
// dividend and divisor that enter the divider chain.
// ----------------------------------------------------------------------------
module psc_front
    import psc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_vld,
    input  psc_in_t    sample,
    input  psc_calib_t cal,
    output psc_div_t   entry
);

    logic [FRONT_STAGES-2:0] vld_reg;

    logic [31:0] s1_a_reg, s1_b_reg;
    logic [19:0] s1_rp_reg, s2_rp_reg, s3_rp_reg, s4_rp_reg, s5_rp_reg, s6_rp_reg;
    logic [19:0] s7_rp_reg, s8_rp_reg, s9_rp_reg;
    logic [15:0] s1_rh_reg, s2_rh_reg, s3_rh_reg, s4_rh_reg, s5_rh_reg;
    logic [31:0] s2_m1_reg, s2_bb_reg, s3_tv1_reg, s3_m2_reg, s4_tf_reg, s4_hx_reg;
    logic [31:0] s5_temp_reg, s6_temp_reg, s7_temp_reg, s8_temp_reg, s9_temp_reg;
    logic [31:0] s10_temp_reg, s11_temp_reg, s12_temp_reg;
    logic [33:0] s5_v1_reg;
    logic [31:0] s5_pa_reg, s5_pb_reg, s5_pc_reg;
    logic signed [33:0] s6_hh_reg;
    logic signed [34:0] s6_hl_reg;
    logic [33:0] s6_ll_reg;
    logic signed [49:0] s6_m5_reg, s6_m2_reg;
    logic [31:0] s6_ha_reg, s7_ha_reg, s8_ha_reg, s9_ha_reg;
    logic [31:0] s6_hb1_reg, s6_hb2_reg, s7_hbm_reg, s8_hbs_reg, s9_hbp_reg;
    logic [63:0] s7_sq_reg, s7_v2a_reg, s7_v1p_reg;
    logic [63:0] s8_sq6_reg, s8_sq3_reg, s8_v2a_reg, s8_v1p_reg;
    logic [63:0] s9_v2_reg, s9_v1b_reg;
    logic [63:0] s10_d0_reg, s10_numa_reg, s11_c_reg, s11_num_reg;
    logic [63:0] s12_den_reg, s12_num_reg;
    logic [31:0] s10_x2_reg, s11_x2_reg, s12_x2_reg, s11_ss_reg, s12_t_reg;
    psc_div_t    entry_reg, entry_next;

    logic [31:0] tf_next, temp_next, hx3_next, hum_clamp;
    logic [31:0] hs_next;
    logic [20:0] pdiff;

    // valid bits of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-3:0], in_vld};
        end
    end

    // combinational pieces that need more than one line
    always_comb
    begin
        tf_next   = s3_tv1_reg + 32'($signed(s3_m2_reg) >>> 14);
        temp_next = 32'($signed({s4_tf_reg[29:0], 2'b0} + s4_tf_reg + C_TEMP_ROUND) >>> 8);
        hs_next   = 32'($signed(s10_x2_reg) >>> 15);
        pdiff     = C_PRESS_FULL - {1'b0, s9_rp_reg};
        hx3_next  = s12_x2_reg - 32'($signed(s12_t_reg) >>> 4);
        if (hx3_next[31])
        begin
            hum_clamp = '0;
        end
        else if (hx3_next > C_HUM_MAX)
        begin
            hum_clamp = C_HUM_MAX;
        end
        else
        begin
            hum_clamp = hx3_next;
        end
        entry_next.vld  = vld_reg[FRONT_STAGES-2];
        entry_next.rem  = '0;
        entry_next.quo  = s12_num_reg[63] ? (64'd0 - s12_num_reg) : s12_num_reg;
        entry_next.den  = s12_den_reg[63] ? (64'd0 - s12_den_reg) : s12_den_reg;
        entry_next.neg  = s12_num_reg[63] ^ s12_den_reg[63];
        entry_next.dz   = (s12_den_reg == '0);
        entry_next.temp = s12_temp_reg;
        entry_next.hum  = hum_clamp[28:12];
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // stage 1: offsets of the raw temperature
        s1_a_reg  <= {15'b0, sample.raw_temperature[19:3]} - {15'b0, cal.t1, 1'b0};
        s1_b_reg  <= {16'b0, sample.raw_temperature[19:4]} - {16'b0, cal.t1};
        s1_rp_reg <= sample.raw_pressure;
        s1_rh_reg <= sample.raw_humidity;
        // stage 2: temperature products
        s2_m1_reg <= s1_a_reg * sx16(cal.t2);
        s2_bb_reg <= s1_b_reg * s1_b_reg;
        s2_rp_reg <= s1_rp_reg;
        s2_rh_reg <= s1_rh_reg;
        // stage 3
        s3_tv1_reg <= 32'($signed(s2_m1_reg) >>> 11);
        s3_m2_reg  <= 32'($signed(s2_bb_reg) >>> 12) * sx16(cal.t3);
        s3_rp_reg  <= s2_rp_reg;
        s3_rh_reg  <= s2_rh_reg;
        // stage 4: fine temperature
        s4_tf_reg <= tf_next;
        s4_hx_reg <= tf_next - C_HUM_TOFS;
        s4_rp_reg <= s3_rp_reg;
        s4_rh_reg <= s3_rh_reg;
        // stage 5: centi-degrees, pressure offset, humidity products
        s5_temp_reg <= temp_next;
        s5_v1_reg   <= {{2{s4_tf_reg[31]}}, s4_tf_reg} - C_PRESS_TOFS;
        s5_pa_reg   <= sx16(cal.h5) * s4_hx_reg;
        s5_pb_reg   <= s4_hx_reg * sx8(cal.h6);
        s5_pc_reg   <= s4_hx_reg * {24'b0, cal.h3};
        s5_rp_reg   <= s4_rp_reg;
        s5_rh_reg   <= s4_rh_reg;
        // stage 6: square in halves, linear pressure terms
        s6_hh_reg  <= $signed(s5_v1_reg[33:17]) * $signed(s5_v1_reg[33:17]);
        s6_hl_reg  <= $signed(s5_v1_reg[33:17]) * $signed({1'b0, s5_v1_reg[16:0]});
        s6_ll_reg  <= s5_v1_reg[16:0] * s5_v1_reg[16:0];
        s6_m5_reg  <= $signed(s5_v1_reg) * $signed(cal.p5);
        s6_m2_reg  <= $signed(s5_v1_reg) * $signed(cal.p2);
        s6_rp_reg  <= s5_rp_reg;
        s6_temp_reg <= s5_temp_reg;
        s6_ha_reg  <= 32'($signed({2'b0, s5_rh_reg, 14'b0} - {cal.h4[11:0], 20'b0}
                          - s5_pa_reg + C_HUM_ROUND) >>> 15);
        s6_hb1_reg <= 32'($signed(s5_pb_reg) >>> 10);
        s6_hb2_reg <= 32'($signed(s5_pc_reg) >>> 11) + C_HUM_HB_OFS;
        // stage 7
        s7_sq_reg  <= ({{30{s6_hh_reg[33]}}, s6_hh_reg} << 34)
                    + ({{29{s6_hl_reg[34]}}, s6_hl_reg} << 18) + {30'b0, s6_ll_reg};
        s7_v2a_reg <= ({{14{s6_m5_reg[49]}}, s6_m5_reg} << 17)
                    + ({{48{cal.p4[15]}}, cal.p4} << 35);
        s7_v1p_reg <= {{14{s6_m2_reg[49]}}, s6_m2_reg} << 12;
        s7_rp_reg  <= s6_rp_reg;
        s7_temp_reg <= s6_temp_reg;
        s7_ha_reg  <= s6_ha_reg;
        s7_hbm_reg <= s6_hb1_reg * s6_hb2_reg;
        // stage 8
        s8_sq6_reg <= mul64x16(s7_sq_reg, {cal.p6[15], cal.p6});
        s8_sq3_reg <= mul64x16(s7_sq_reg, {cal.p3[15], cal.p3});
        s8_v2a_reg <= s7_v2a_reg;
        s8_v1p_reg <= s7_v1p_reg;
        s8_rp_reg  <= s7_rp_reg;
        s8_temp_reg <= s7_temp_reg;
        s8_ha_reg  <= s7_ha_reg;
        s8_hbs_reg <= 32'($signed(s7_hbm_reg) >>> 10) + C_HUM_HC_OFS;
        // stage 9
        s9_v2_reg  <= s8_sq6_reg + s8_v2a_reg;
        s9_v1b_reg <= 64'($signed(s8_sq3_reg) >>> 8) + s8_v1p_reg;
        s9_rp_reg  <= s8_rp_reg;
        s9_temp_reg <= s8_temp_reg;
        s9_ha_reg  <= s8_ha_reg;
        s9_hbp_reg <= s8_hbs_reg * sx16(cal.h2) + C_HUM_HD_RND;
        // stage 10
        s10_d0_reg   <= C_PRESS_BIAS + s9_v1b_reg;
        s10_numa_reg <= ({43'b0, pdiff} << 31) - s9_v2_reg;
        s10_temp_reg <= s9_temp_reg;
        s10_x2_reg   <= s9_ha_reg * 32'($signed(s9_hbp_reg) >>> 14);
        // stage 11
        s11_c_reg    <= mul64x16(s10_d0_reg, {1'b0, cal.p1});
        s11_num_reg  <= mul64x16(s10_numa_reg, C_PRESS_SCALE);
        s11_temp_reg <= s10_temp_reg;
        s11_x2_reg   <= s10_x2_reg;
        s11_ss_reg   <= hs_next * hs_next;
        // stage 12
        s12_den_reg  <= 64'($signed(s11_c_reg) >>> 33);
        s12_num_reg  <= s11_num_reg;
        s12_temp_reg <= s11_temp_reg;
        s12_x2_reg   <= s11_x2_reg;
        s12_t_reg    <= 32'($signed(s11_ss_reg) >>> 7) * {24'b0, cal.h1};
    end

    // stage 13: magnitudes into the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/psc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_div_cell
// One restoring division step: decides one quotient bit and hands the
// partial remainder and the request's other fields to the next cell.
// ----------------------------------------------------------------------------
module psc_div_cell
    import psc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  psc_div_t d_in,
    output psc_div_t d_out
);

    psc_div_t    cell_reg, cell_next;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic        fits;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        shifted = {d_in.rem, d_in.quo[63]};
        diff    = shifted - {1'b0, d_in.den};
        fits    = (shifted >= {1'b0, d_in.den});
        cell_next     = d_in;
        cell_next.rem = fits ? diff[63:0] : shifted[63:0];
        cell_next.quo = {d_in.quo[62:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

FILE: rtl/psc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_back
// Sign of the quotient and the final pressure correction terms; holds
// the result register.
// ----------------------------------------------------------------------------
module psc_back
    import psc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  psc_div_t   d_in,
    input  psc_calib_t cal,
    output logic       done,
    output psc_out_t   result
);

    logic [BACK_STAGES-2:0] vld_reg;
    logic        done_reg;
    psc_out_t    result_reg;

    logic [63:0] b1_p_reg, b2_p_reg, b3_p_reg, b4_p_reg;
    logic [63:0] b2_qqlo_reg, b2_w2m_reg, b3_qq_reg, b3_w2_reg, b4_w2_reg, b4_w1m_reg;
    logic [31:0] b2_qqx_reg;
    logic [63:0] b5_s_reg;
    logic [63:0] q_next, press_next;
    logic        b1_dz_reg, b2_dz_reg, b3_dz_reg, b4_dz_reg, b5_dz_reg;
    logic [31:0] b1_temp_reg, b2_temp_reg, b3_temp_reg, b4_temp_reg, b5_temp_reg;
    logic [16:0] b1_hum_reg, b2_hum_reg, b3_hum_reg, b4_hum_reg, b5_hum_reg;

    always_comb
    begin
        q_next     = 64'($signed(b1_p_reg) >>> 13);
        press_next = 64'($signed(b5_s_reg) >>> 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);
    end

    // valid bits and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            vld_reg  <= {vld_reg[BACK_STAGES-3:0], d_in.vld};
            done_reg <= vld_reg[BACK_STAGES-2];
            result_reg.temperature_centi <= $signed(b5_temp_reg);
            result_reg.pressure_q24_8    <= b5_dz_reg ? 32'd0 : press_next[31:0];
            result_reg.humidity_q22_10   <= b5_hum_reg;
        end
    end

    // pressure correction stages
    always_ff @(posedge clk)
    begin
        // signed quotient
        b1_p_reg    <= d_in.neg ? (64'd0 - d_in.quo) : d_in.quo;
        b1_dz_reg   <= d_in.dz;
        b1_temp_reg <= d_in.temp;
        b1_hum_reg  <= d_in.hum;
        // square of the scaled quotient in halves
        b2_qqlo_reg <= q_next[31:0] * q_next[31:0];
        b2_qqx_reg  <= q_next[31:0] * q_next[63:32];
        b2_w2m_reg  <= mul64x16(b1_p_reg, {cal.p8[15], cal.p8});
        b2_p_reg    <= b1_p_reg;
        b2_dz_reg   <= b1_dz_reg;
        b2_temp_reg <= b1_temp_reg;
        b2_hum_reg  <= b1_hum_reg;
        // stage 3
        b3_qq_reg   <= b2_qqlo_reg + {b2_qqx_reg[30:0], 33'b0};
        b3_w2_reg   <= 64'($signed(b2_w2m_reg) >>> 19);
        b3_p_reg    <= b2_p_reg;
        b3_dz_reg   <= b2_dz_reg;
        b3_temp_reg <= b2_temp_reg;
        b3_hum_reg  <= b2_hum_reg;
        // stage 4
        b4_w1m_reg  <= mul64x16(b3_qq_reg, {cal.p9[15], cal.p9});
        b4_w2_reg   <= b3_w2_reg;
        b4_p_reg    <= b3_p_reg;
        b4_dz_reg   <= b3_dz_reg;
        b4_temp_reg <= b3_temp_reg;
        b4_hum_reg  <= b3_hum_reg;
        // stage 5
        b5_s_reg    <= b4_p_reg + 64'($signed(b4_w1m_reg) >>> 25) + b4_w2_reg;
        b5_dz_reg   <= b4_dz_reg;
        b5_temp_reg <= b4_temp_reg;
        b5_hum_reg  <= b4_hum_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/pth_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation
// A request taken at one clock edge shows its result with done high after
// it passes 13 front stages, 64 divider cells and 6 back stages.
// Throughput: one request per cycle while busy is low; the 64-cell divider
// chain sets the depth. The receiver cannot stall; done is a one-cycle strobe.
// Reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module pth_sensor_compensation
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psc_in_t              sample,
    output logic                 done,
    output psc_out_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic        busy_reg;
    logic [47:0] temp_calib_reg, mixed_calib_reg;
    logic [63:0] press_low_reg, press_high_reg;
    logic [39:0] hum_calib_reg;
    psc_calib_t  cal;
    logic        accept;
    psc_div_t    chain [0:DIV_BITS];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // held off for the first cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg  <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            mixed_calib_reg <= '0;
            hum_calib_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_CALIB:  temp_calib_reg  <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_MIXED_CALIB: mixed_calib_reg <= cfg_data[47:0];
                REG_HUM_CALIB:   hum_calib_reg   <= cfg_data[39:0];
                default:         ;
            endcase
        end
    end

    // calibration word decode
    always_comb
    begin
        cal.t1 = temp_calib_reg[15:0];
        cal.t2 = temp_calib_reg[31:16];
        cal.t3 = temp_calib_reg[47:32];
        cal.p1 = press_low_reg[15:0];
        cal.p2 = press_low_reg[31:16];
        cal.p3 = press_low_reg[47:32];
        cal.p4 = press_low_reg[63:48];
        cal.p5 = press_high_reg[15:0];
        cal.p6 = press_high_reg[31:16];
        cal.p7 = press_high_reg[47:32];
        cal.p8 = press_high_reg[63:48];
        cal.p9 = mixed_calib_reg[15:0];
        cal.h1 = mixed_calib_reg[23:16];
        cal.h2 = mixed_calib_reg[39:24];
        cal.h3 = mixed_calib_reg[47:40];
        cal.h4 = hum_calib_reg[15:0];
        cal.h5 = hum_calib_reg[31:16];
        cal.h6 = hum_calib_reg[39:32];
    end

    // formulas up to the division
    psc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (accept),
        .sample (sample),
        .cal    (cal),
        .entry  (chain[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar i = 0; i < DIV_BITS; i++)
    begin : g_div
        psc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    // final pressure terms and result register
    psc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .d_in   (chain[DIV_BITS]),
        .cal    (cal),
        .done   (done),
        .result (result)
    );

    // every request leaves after the fixed latency
    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request did not produce a result");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without request");

    // humidity stays in the clamped range
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.humidity_q22_10 <= 17'd102400))
        else $error("humidity out of range");

    // zero divisor forces zero pressure
    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        chain[DIV_BITS].vld && chain[DIV_BITS].dz |-> ##BACK_STAGES
        (result.pressure_q24_8 == 32'd0))
        else $error("pressure not zero for zero divisor");

endmodule

FILE: tb/pth_sensor_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation_test
// Drives raw sample sets through the compensation block under several
// calibration settings and start/idle patterns, predicts each compensated
// result in integer arithmetic and checks every done strobe in order.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_test
    import psc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = LATENCY + 20;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    psc_in_t  sample;
    logic     done;
    psc_out_t result;
    logic     cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int error_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int settings_used = 0;

    // calibration shadow
    logic [63:0] calib_shadow [5];

    // mismatch reporting
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sext64(input logic [63:0] v, input int pos,
                                           input int len);
        logic [63:0] m;
        logic [63:0] x;
        m = (64'd1 << len) - 64'd1;
        x = (v >> pos) & m;
        if (x[len-1])
            x = x | ~m;
        return x;
    endfunction

    // compensated outputs for one raw sample set
    function automatic psc_out_t compensate(input psc_in_t s);
        psc_out_t o;
        logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, tv1, b, tv2, tfine, x, ha, hb, sq;
        logic [63:0] v1, v2, p, q, w1, w2, an, ad, num;
        logic [31:0] rt, rh;
        rt = {12'd0, s.raw_temperature};
        rh = {16'd0, s.raw_humidity};
        t1 = {16'd0, calib_shadow[REG_TEMP_CALIB][15:0]};
        t2 = 32'(sext64(calib_shadow[REG_TEMP_CALIB], 16, 16));
        t3 = 32'(sext64(calib_shadow[REG_TEMP_CALIB], 32, 16));
        p1 = {48'd0, calib_shadow[REG_PRESS_LOW][15:0]};
        p2 = sext64(calib_shadow[REG_PRESS_LOW], 16, 16);
        p3 = sext64(calib_shadow[REG_PRESS_LOW], 32, 16);
        p4 = sext64(calib_shadow[REG_PRESS_LOW], 48, 16);
        p5 = sext64(calib_shadow[REG_PRESS_HIGH], 0, 16);
        p6 = sext64(calib_shadow[REG_PRESS_HIGH], 16, 16);
        p7 = sext64(calib_shadow[REG_PRESS_HIGH], 32, 16);
        p8 = sext64(calib_shadow[REG_PRESS_HIGH], 48, 16);
        p9 = sext64(calib_shadow[REG_MIXED_CALIB], 0, 16);
        h1 = {24'd0, calib_shadow[REG_MIXED_CALIB][23:16]};
        h2 = 32'(sext64(calib_shadow[REG_MIXED_CALIB], 24, 16));
        h3 = {24'd0, calib_shadow[REG_MIXED_CALIB][47:40]};
        h4 = 32'(sext64(calib_shadow[REG_HUM_CALIB], 0, 16));
        h5 = 32'(sext64(calib_shadow[REG_HUM_CALIB], 16, 16));
        h6 = 32'(sext64(calib_shadow[REG_HUM_CALIB], 32, 8));

        // temperature
        a = (rt >> 3) - (t1 << 1);
        tv1 = sra32(a * t2, 11);
        b = (rt >> 4) - t1;
        tv2 = sra32(sra32(b * b, 12) * t3, 14);
        tfine = tv1 + tv2;
        o.temperature_centi = sra32(tfine * 32'd5 + 32'd128, 8);

        // pressure
        v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            o.pressure_q24_8 = 32'd0;
        end
        else begin
            p = 64'd1048576 - {44'd0, s.raw_pressure};
            num = ((p << 31) - v2) * 64'd3125;
            an = num[63] ? -num : num;
            ad = v1[63] ? -v1 : v1;
            p = an / ad;
            if (num[63] != v1[63])
                p = -p;
            q = sra64(p, 13);
            w1 = sra64(p9 * q * q, 25);
            w2 = sra64(p8 * p, 19);
            p = sra64(p + w1 + w2, 8) + (p7 << 4);
            o.pressure_q24_8 = p[31:0];
        end

        // humidity
        x = tfine - 32'd76800;
        ha = sra32((rh << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        hb = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
        hb = sra32(hb, 10) + 32'd2097152;
        hb = sra32(hb * h2 + 32'd8192, 14);
        x = ha * hb;
        sq = sra32(x, 15);
        x = x - sra32(sra32(sq * sq, 7) * h1, 4);
        if (x[31])
            x = 32'd0;
        else if (x > 32'd419430400)
            x = 32'd419430400;
        o.humidity_q22_10 = x[28:12];
        return o;
    endfunction

    // in-order store of predicted results
    class compensation_scoreboard;
        psc_out_t pending[$];

        function void note_request(input psc_in_t s);
            pending.push_back(compensate(s));
        endfunction

        task check_result(input psc_out_t got);
            psc_out_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            want = pending.pop_front();
            results_checked++;
            if (got.temperature_centi !== want.temperature_centi)
                report_mismatch($sformatf("temperature got %0d want %0d",
                    got.temperature_centi, want.temperature_centi));
            if (got.pressure_q24_8 !== want.pressure_q24_8)
                report_mismatch($sformatf("pressure got %0h want %0h",
                    got.pressure_q24_8, want.pressure_q24_8));
            if (got.humidity_q22_10 !== want.humidity_q22_10)
                report_mismatch($sformatf("humidity got %0h want %0h",
                    got.humidity_q22_10, want.humidity_q22_10));
        endtask
    endclass

    compensation_scoreboard board;

    // block under test
    pth_sensor_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result sampling and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                board.check_result(result);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("simulation failed");
                $finish;
            end
        end
    end

    // write enable stays high; the load task drops it after its last write
    task automatic write_calib(input psc_reg_e idx, input logic [63:0] val);
        logic [63:0] m;
        case (idx)
            REG_TEMP_CALIB, REG_MIXED_CALIB: m = 64'h0000_FFFF_FFFF_FFFF;
            REG_HUM_CALIB:                  m = 64'h0000_00FF_FFFF_FFFF;
            default:                        m = '1;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        calib_shadow[idx] = val & m;
    endtask

    // waits until all predicted results have come, then the pipe settles
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // start stays high after the accepting edge until the next idle or drain
    task automatic send_request(input psc_in_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(s);
        requests_sent++;
    endtask

    function automatic psc_in_t random_sample();
        psc_in_t s;
        s.raw_temperature = 20'($urandom);
        s.raw_pressure    = 20'($urandom);
        s.raw_humidity    = 16'($urandom);
        case ($urandom_range(5))
            0: s.raw_temperature = '1;
            1: s.raw_pressure = '0;
            2: s.raw_humidity = '1;
            default: ;
        endcase
        return s;
    endfunction

    // realistic calibration around typical sensor values, fields jittered
    task automatic load_typical();
        logic [15:0] t1, p1;
        t1 = 16'd27504 + 16'($urandom_range(2000)) - 16'd1000;
        p1 = 16'd36477 + 16'($urandom_range(4000)) - 16'd2000;
        write_calib(REG_TEMP_CALIB, 64'({16'd50, 16'd26435, t1}));
        write_calib(REG_PRESS_LOW,
            {16'd2855, 16'd3024, 16'hD5DC + 16'($urandom_range(64)), p1});
        write_calib(REG_PRESS_HIGH, {16'hC0E3, 16'd15500, 16'hFFF9, 16'd140});
        write_calib(REG_MIXED_CALIB,
            64'({8'd0, 16'd360 + 16'($urandom_range(40)), 8'd75, 16'd6000}));
        write_calib(REG_HUM_CALIB,
            64'({8'd30, 16'd50, 16'd300 + 16'($urandom_range(40))}));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic load_random();
        for (int i = 0; i < 5; i++)
            write_calib(psc_reg_e'(i), {$urandom, $urandom});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic load_fill(input logic [63:0] val);
        for (int i = 0; i < 5; i++)
            write_calib(psc_reg_e'(i), val);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        psc_in_t s;
        int phase_idle [4] = '{0, 76, 0, 19};
        board = new();
        for (int i = 0; i < 5; i++)
            calib_shadow[i] = '0;
        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero calibration, then extremes and typical values
        s = '{20'd0, 20'd0, 16'd0};
        send_request(s);
        s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF};
        send_request(s);
        drain();
        load_fill('1);
        send_request('{20'd0, 20'd0, 16'd0});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_request('{20'h55555, 20'hAAAAA, 16'h5555});
        drain();
        load_fill(64'h8000_8000_8000_8000);
        send_request('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_request('{20'd0, 20'hFFFFF, 16'd0});
        drain();
        load_typical();
        send_request('{20'd519888, 20'd415148, 16'd27000});
        send_request('{20'd0, 20'd0, 16'd0});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_request('{20'd400000, 20'd300000, 16'd65535});
        send_request('{20'd600000, 20'd500000, 16'd0});
        drain();

        // random phases: mostly realistic calibration, some random ones
        for (int ph = 0; ph < 16; ph++) begin
            send_idle_pct = phase_idle[ph % 4];
            if (ph % 3 == 2)
                load_random();
            else
                load_typical();
            for (int n = 0; n < 125; n++)
                send_request(random_sample());
            drain();
        end

        $display("covered %0d requests, %0d results checked, %0d calibration settings",
                 requests_sent, results_checked, settings_used);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
